// ===== hdl/apseq_pkg.sv =====
// apseq_pkg: shared types and constants for the accessory power sequencer
`default_nettype none

package apseq_pkg;

  typedef enum logic [2:0] {
    MODE_OFF  = 3'd0,
    MODE_BOOT = 3'd1,
    MODE_ON   = 3'd2,
    MODE_WAIT = 3'd3,
    MODE_SHUT = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PH_CONTACT_OFF   = 2'd0,
    PH_LOCK_INACTIVE = 2'd1,
    PH_LOCK_ACTIVE   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    IR_NONE    = 3'd0,
    IR_POWER   = 3'd1,
    IR_VOLUP   = 3'd2,
    IR_VOLDOWN = 3'd3,
    IR_REPEAT  = 3'd4
  } ir_t;

  // configuration register indexes
  localparam logic [1:0] CFG_RECENT_BLINK_LIMIT = 2'd0;
  localparam logic [1:0] CFG_BOOT_TIMEOUT       = 2'd1;
  localparam logic [1:0] CFG_WAIT_TIMEOUT       = 2'd2;

  localparam logic [15:0] RECENT_BLINK_LIMIT_RST = 16'd15;
  localparam logic [15:0] BOOT_TIMEOUT_RST       = 16'd2160;
  localparam logic [15:0] WAIT_TIMEOUT_RST       = 16'd1440;

  // timer thresholds
  localparam logic [15:0] T_BOOT_POWER   = 16'd39;
  localparam logic [15:0] T_BOOT_VOL     = 16'd200;
  localparam logic [15:0] T_BOOT_HOLD    = 16'd241;
  localparam logic [15:0] T_BOOT_PRESET  = 16'd242;
  localparam logic [15:0] T_SHUT_PRESET  = 16'd51;
  localparam logic [15:0] T_SHUT_POWER   = 16'd52;
  localparam logic [15:0] T_SHUT_REPEAT  = 16'd53;
  localparam logic [15:0] T_SHUT_ON_MAX  = 16'd50;
  localparam logic [15:0] T_SHUT_RELAY   = 16'd90;
  localparam logic [15:0] T_SHUT_END     = 16'd140;
  localparam logic [15:0] T_MAX          = 16'hFFFF;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] ticks_in_state;
    logic [15:0] ticks_since_blink;
    phase_t      phase;
  } apseq_state_t;

  typedef struct packed {
    logic [15:0] recent_blink_limit;
    logic [15:0] boot_timeout;
    logic [15:0] wait_timeout;
  } apseq_cfg_t;

  typedef struct packed {
    logic  led_red;
    logic  green_lamp;
    logic  relay_on;
    ir_t   ir_request;
    mode_t power_mode;
  } apseq_res_t;

endpackage

`default_nettype wire

// ===== hdl/apseq_step.sv =====
// apseq_step: next-state and result logic for one tick
`default_nettype none

module apseq_step (
  input  apseq_pkg::apseq_state_t state,
  input  apseq_pkg::apseq_cfg_t   cfg,
  input  logic                    ignition_level,
  input  logic                    lock_level,
  input  logic                    blinker_level,
  output apseq_pkg::apseq_state_t state_nxt,
  output apseq_pkg::apseq_res_t   res
);
  import apseq_pkg::*;

  logic        ign_off;
  logic        blink_idle;
  logic        recent;
  logic [15:0] t;
  logic [15:0] t_set;
  mode_t       mode_nxt;
  phase_t      phase_nxt;
  ir_t         ir;
  logic        red;
  logic        green;
  logic        relay;

  assign ign_off    = ignition_level;
  assign blink_idle = blinker_level;
  assign recent     = state.ticks_since_blink < cfg.recent_blink_limit;
  assign t          = state.ticks_in_state;

  // mode transitions, timer presets and key requests
  always_comb begin
    mode_nxt  = state.mode;
    phase_nxt = state.phase;
    t_set     = t;
    ir        = IR_NONE;
    unique case (state.mode)
      MODE_BOOT: begin
        if (!lock_level && ign_off && recent) begin
          if (t < T_BOOT_POWER) begin
            mode_nxt = MODE_OFF;
            t_set    = '0;
          end else if (t < T_BOOT_VOL) begin
            mode_nxt = MODE_SHUT;
            t_set    = T_SHUT_PRESET;
          end else begin
            mode_nxt = MODE_SHUT;
            t_set    = '0;
          end
        end else if (t == T_BOOT_POWER) begin
          ir = IR_POWER;
        end else if (t > T_BOOT_VOL) begin
          if (t <= T_BOOT_HOLD) begin
            if (t[1:0] == 2'b11) ir = IR_VOLUP;
          end else if (!blink_idle) begin
            t_set = T_BOOT_PRESET;
          end else if (!ign_off) begin
            mode_nxt = MODE_ON;
            t_set    = '0;
          end else if (t > cfg.boot_timeout) begin
            mode_nxt = MODE_SHUT;
            t_set    = '0;
          end
        end
      end
      MODE_ON: begin
        if (ign_off) begin
          phase_nxt = PH_CONTACT_OFF;
          mode_nxt  = MODE_WAIT;
          t_set     = '0;
        end
      end
      MODE_WAIT: begin
        if (state.phase == PH_CONTACT_OFF) begin
          if (lock_level) phase_nxt = PH_LOCK_INACTIVE;
        end else if (state.phase == PH_LOCK_INACTIVE) begin
          if (!lock_level && ign_off && recent) phase_nxt = PH_LOCK_ACTIVE;
        end
        if (!ign_off) begin
          mode_nxt = MODE_ON;
          t_set    = '0;
        end else if (t > cfg.wait_timeout || phase_nxt == PH_LOCK_ACTIVE) begin
          mode_nxt = MODE_SHUT;
          t_set    = '0;
        end
      end
      MODE_SHUT: begin
        if (!ign_off || (lock_level && recent)) begin
          if (t <= T_SHUT_ON_MAX) begin
            mode_nxt = MODE_ON;
            t_set    = '0;
          end else if (t <= T_SHUT_RELAY) begin
            // power-off code still running
          end else if (t <= T_SHUT_END) begin
            mode_nxt = MODE_BOOT;
            t_set    = '0;
          end
        end else if (t > T_SHUT_END) begin
          mode_nxt = MODE_OFF;
          t_set    = '0;
        end else if (t >= T_SHUT_RELAY) begin
          // waiting for relay release
        end else if (t >= T_SHUT_REPEAT) begin
          ir = IR_REPEAT;
        end else if (t == T_SHUT_POWER) begin
          ir = IR_POWER;
        end else if (t < T_SHUT_ON_MAX && t[0]) begin
          ir = IR_VOLDOWN;
        end
      end
      default: begin
        // off, and any unused mode code
        if (!ign_off || (recent && lock_level)) begin
          mode_nxt = MODE_BOOT;
          t_set    = '0;
        end
      end
    endcase
  end

  // pin levels come from the mode held at the start of the tick
  always_comb begin
    unique case (state.mode)
      MODE_BOOT: begin red = 1'b1; green = 1'b0; relay = 1'b1; end
      MODE_ON:   begin red = 1'b0; green = 1'b0; relay = 1'b1; end
      MODE_WAIT: begin red = 1'b0; green = 1'b1; relay = 1'b1; end
      MODE_SHUT: begin red = 1'b0; green = 1'b1; relay = 1'b1; end
      default:   begin red = 1'b1; green = 1'b1; relay = 1'b0; end
    endcase
  end

  always_comb begin
    state_nxt.mode           = mode_nxt;
    state_nxt.phase          = phase_nxt;
    state_nxt.ticks_in_state = (t_set == T_MAX) ? t_set : t_set + 16'd1;
    if (!blink_idle) begin
      state_nxt.ticks_since_blink = '0;
    end else if (state.ticks_since_blink == T_MAX) begin
      state_nxt.ticks_since_blink = state.ticks_since_blink;
    end else begin
      state_nxt.ticks_since_blink = state.ticks_since_blink + 16'd1;
    end
  end

  assign res.led_red    = red;
  assign res.green_lamp = green;
  assign res.relay_on   = relay;
  assign res.ir_request = ir;
  assign res.power_mode = mode_nxt;

endmodule

`default_nettype wire

// ===== hdl/accessory_power_sequencer.sv =====
// accessory_power_sequencer: top level with input register, state and result register
// each item goes from the input register through the step logic into the result register
// throughput: one item per cycle while out_stall is low, set by the single pass through the step logic
// while a result waits on out_stall the input register takes one more item, then stalls
// reset (synchronous, rst_n low): mode off, counters zero, lock phase contact off,
// configuration back to its defaults (limit 15, boot 2160, wait 1440), both registers empty
`default_nettype none

module accessory_power_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // tick items in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_ignition_level,
  input  logic        in_lock_level,
  input  logic        in_blinker_level,
  // result items out
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_led_red,
  output logic        out_green_lamp,
  output logic        out_relay_on,
  output logic [2:0]  out_ir_request,
  output logic [2:0]  out_power_mode
);
  import apseq_pkg::*;

  // configuration registers
  apseq_cfg_t   cfg_r;

  // sequencer state, advanced once per item
  apseq_state_t state_r;
  apseq_state_t state_nxt;

  // input register
  logic         in_valid_r;
  logic         in_ign_r;
  logic         in_lock_r;
  logic         in_blink_r;

  // result register
  logic         out_valid_r;
  apseq_res_t   res_nxt;
  apseq_res_t   res_r;

  logic         advance;   // item moves from input to result register
  logic         in_load;   // input register takes a new item

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.recent_blink_limit <= RECENT_BLINK_LIMIT_RST;
      cfg_r.boot_timeout       <= BOOT_TIMEOUT_RST;
      cfg_r.wait_timeout       <= WAIT_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RECENT_BLINK_LIMIT: cfg_r.recent_blink_limit <= cfg_wdata;
        CFG_BOOT_TIMEOUT:       cfg_r.boot_timeout       <= cfg_wdata;
        CFG_WAIT_TIMEOUT:       cfg_r.wait_timeout       <= cfg_wdata;
        default: ;  // index beyond the list, ignored
      endcase
    end
  end

  // input register: valid under reset, payload free-running on load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_ign_r   <= in_ignition_level;
      in_lock_r  <= in_lock_level;
      in_blink_r <= in_blinker_level;
    end
  end

  apseq_step u_step (
    .state          (state_r),
    .cfg            (cfg_r),
    .ignition_level (in_ign_r),
    .lock_level     (in_lock_r),
    .blinker_level  (in_blink_r),
    .state_nxt      (state_nxt),
    .res            (res_nxt)
  );

  // state only moves when an item is actually consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode              <= MODE_OFF;
      state_r.ticks_in_state    <= '0;
      state_r.ticks_since_blink <= '0;
      state_r.phase             <= PH_CONTACT_OFF;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_red    = res_r.led_red;
  assign out_green_lamp = res_r.green_lamp;
  assign out_relay_on   = res_r.relay_on;
  assign out_ir_request = res_r.ir_request;
  assign out_power_mode = res_r.power_mode;

endmodule

`default_nettype wire

// ===== hdl/apseq_checker.sv =====
// apseq_checker: port-level assertions for the accessory power sequencer, with bind
`default_nettype none

module apseq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_led_red,
  input logic       out_green_lamp,
  input logic       out_relay_on,
  input logic [2:0] out_ir_request,
  input logic [2:0] out_power_mode
);
  import apseq_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_power_mode)
      && $stable(out_ir_request) && $stable(out_relay_on))
    else $error("stalled item changed");

  // relay released only from off, which can only stay off or go to boot
  a_relay_off_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_relay_on |->
      (out_power_mode == MODE_OFF || out_power_mode == MODE_BOOT)
      && out_led_red && out_green_lamp && out_ir_request == IR_NONE)
    else $error("relay off outside off mode");

  // a key code is only sent with the relay on
  a_ir_needs_relay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ir_request != IR_NONE |-> out_relay_on)
    else $error("key code sent with relay off");

endmodule

bind accessory_power_sequencer apseq_checker u_apseq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_led_red    (out_led_red),
  .out_green_lamp (out_green_lamp),
  .out_relay_on   (out_relay_on),
  .out_ir_request (out_ir_request),
  .out_power_mode (out_power_mode)
);

`default_nettype wire

// ===== verif/apseq_check.sv =====
// apseq_check: watches both channels, predicts each result item and compares it
module apseq_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_ignition_level,
  input  logic        in_lock_level,
  input  logic        in_blinker_level,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_led_red,
  input  logic        out_green_lamp,
  input  logic        out_relay_on,
  input  logic [2:0]  out_ir_request,
  input  logic [2:0]  out_power_mode,
  output int          mismatches,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import apseq_pkg::*;

  // predicted sequencer state and its register copy
  mode_t       mode_q;
  logic [15:0] ticks_q;
  logic [15:0] since_blink_q;
  phase_t      phase_q;
  apseq_cfg_t  regs;

  apseq_res_t  due_q[$];
  apseq_res_t  want;

  initial mismatches = 0;
  initial results_due = 0;

  task automatic note_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void enter_mode(mode_t m);
    mode_q  = m;
    ticks_q = '0;
  endfunction

  // one tick of the sequencer: outputs from the mode held at the start of the tick
  function automatic apseq_res_t advance_power_mode(logic ign_off, logic lock_pin,
                                                    logic blink_idle);
    logic        recent;
    logic [15:0] t;
    apseq_res_t  r;
    recent       = since_blink_q < regs.recent_blink_limit;
    t            = ticks_q;
    r.ir_request = IR_NONE;
    case (mode_q)
      MODE_BOOT: begin
        r.led_red = 1'b1; r.green_lamp = 1'b0; r.relay_on = 1'b1;
        if (!lock_pin && ign_off && recent) begin
          if (t < T_BOOT_POWER) begin
            enter_mode(MODE_OFF);
          end else if (t < T_BOOT_VOL) begin
            enter_mode(MODE_SHUT);
            ticks_q = T_SHUT_PRESET;
          end else begin
            enter_mode(MODE_SHUT);
          end
        end else if (t == T_BOOT_POWER) begin
          r.ir_request = IR_POWER;
        end else if (t > T_BOOT_VOL) begin
          if (t <= T_BOOT_HOLD) begin
            if (t[1:0] == 2'b11) r.ir_request = IR_VOLUP;
          end else if (!blink_idle) begin
            ticks_q = T_BOOT_PRESET;
          end else if (!ign_off) begin
            enter_mode(MODE_ON);
          end else if (t > regs.boot_timeout) begin
            enter_mode(MODE_SHUT);
          end
        end
      end
      MODE_ON: begin
        r.led_red = 1'b0; r.green_lamp = 1'b0; r.relay_on = 1'b1;
        if (ign_off) begin
          phase_q = PH_CONTACT_OFF;
          enter_mode(MODE_WAIT);
        end
      end
      MODE_WAIT: begin
        r.led_red = 1'b0; r.green_lamp = 1'b1; r.relay_on = 1'b1;
        if (phase_q == PH_CONTACT_OFF) begin
          if (lock_pin) phase_q = PH_LOCK_INACTIVE;
        end else if (phase_q == PH_LOCK_INACTIVE) begin
          if (!lock_pin && ign_off && recent) phase_q = PH_LOCK_ACTIVE;
        end
        if (!ign_off) begin
          enter_mode(MODE_ON);
        end else if (t > regs.wait_timeout || phase_q == PH_LOCK_ACTIVE) begin
          enter_mode(MODE_SHUT);
        end
      end
      MODE_SHUT: begin
        r.led_red = 1'b0; r.green_lamp = 1'b1; r.relay_on = 1'b1;
        if (!ign_off || (lock_pin && recent)) begin
          // resume window; between on and boot the power-off code runs out
          if (t <= T_SHUT_ON_MAX) begin
            enter_mode(MODE_ON);
          end else if (t > T_SHUT_RELAY && t <= T_SHUT_END) begin
            enter_mode(MODE_BOOT);
          end
        end else if (t > T_SHUT_END) begin
          enter_mode(MODE_OFF);
        end else if (t >= T_SHUT_RELAY) begin
          r.ir_request = IR_NONE;
        end else if (t >= T_SHUT_REPEAT) begin
          r.ir_request = IR_REPEAT;
        end else if (t == T_SHUT_POWER) begin
          r.ir_request = IR_POWER;
        end else if (t < T_SHUT_ON_MAX && t[0]) begin
          r.ir_request = IR_VOLDOWN;
        end
      end
      default: begin
        r.led_red = 1'b1; r.green_lamp = 1'b1; r.relay_on = 1'b0;
        if (!ign_off || (recent && lock_pin)) enter_mode(MODE_BOOT);
      end
    endcase
    if (!blink_idle) since_blink_q = '0;
    else if (since_blink_q != T_MAX) since_blink_q = since_blink_q + 16'd1;
    if (ticks_q != T_MAX) ticks_q = ticks_q + 16'd1;
    r.power_mode = mode_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q        = MODE_OFF;
      ticks_q       = '0;
      since_blink_q = '0;
      phase_q       = PH_CONTACT_OFF;
      regs          = '{RECENT_BLINK_LIMIT_RST, BOOT_TIMEOUT_RST, WAIT_TIMEOUT_RST};
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RECENT_BLINK_LIMIT: regs.recent_blink_limit = cfg_wdata;
          CFG_BOOT_TIMEOUT:       regs.boot_timeout       = cfg_wdata;
          CFG_WAIT_TIMEOUT:       regs.wait_timeout       = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        due_q.push_back(advance_power_mode(in_ignition_level, in_lock_level,
                                           in_blinker_level));
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          note_mismatch("result item with no tick outstanding");
        end else begin
          want = due_q.pop_front();
          if (out_led_red !== want.led_red)
            note_mismatch($sformatf("led_red %b, want %b", out_led_red, want.led_red));
          if (out_green_lamp !== want.green_lamp)
            note_mismatch($sformatf("green_lamp %b, want %b", out_green_lamp,
                                    want.green_lamp));
          if (out_relay_on !== want.relay_on)
            note_mismatch($sformatf("relay_on %b, want %b", out_relay_on, want.relay_on));
          if (out_ir_request !== want.ir_request)
            note_mismatch($sformatf("ir_request %0d, want %0d", out_ir_request,
                                    want.ir_request));
          if (out_power_mode !== want.power_mode)
            note_mismatch($sformatf("power_mode %0d, want %0d", out_power_mode,
                                    want.power_mode));
        end
      end
    end
    results_due <= due_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// testbench: tick stimulus, register settings and verdict for the accessory power sequencer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import apseq_pkg::*;

  // roughly 19 percent idle on each side
  localparam int IDLE_PCT       = 19;
  // cycles with no item moving on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_TICKS    = 140;
  // ignition-on stretch at full-scale settings
  localparam int SOAK_TICKS     = 40;

  // opening ticks, {ignition, lock, blinker} per item, first item in the top bits
  localparam logic [71:0] OPENING = {
    3'b101, 3'b111, 3'b111, 3'b100, 3'b001, 3'b010, 3'b101, 3'b110,
    3'b000, 3'b011, 3'b000, 3'b100, 3'b000, 3'b110, 3'b101, 3'b011,
    3'b001, 3'b010, 3'b111, 3'b101, 3'b100, 3'b110, 3'b011, 3'b001
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_RECENT_BLINK_LIMIT;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ignition_level = 1'b1;
  logic        in_lock_level = 1'b0;
  logic        in_blinker_level = 1'b1;
  logic        out_stall = 1'b0;
  logic        quiet = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        out_led_red;
  logic        out_green_lamp;
  logic        out_relay_on;
  logic [2:0]  out_ir_request;
  logic [2:0]  out_power_mode;

  int          mismatches;
  int          results_due;
  int          idle_run = 0;
  int          ticks_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  accessory_power_sequencer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ignition_level (in_ignition_level),
    .in_lock_level     (in_lock_level),
    .in_blinker_level  (in_blinker_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_led_red       (out_led_red),
    .out_green_lamp    (out_green_lamp),
    .out_relay_on      (out_relay_on),
    .out_ir_request    (out_ir_request),
    .out_power_mode    (out_power_mode)
  );

  apseq_check check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ignition_level (in_ignition_level),
    .in_lock_level     (in_lock_level),
    .in_blinker_level  (in_blinker_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_led_red       (out_led_red),
    .out_green_lamp    (out_green_lamp),
    .out_relay_on      (out_relay_on),
    .out_ir_request    (out_ir_request),
    .out_power_mode    (out_power_mode),
    .mismatches        (mismatches),
    .results_due       (results_due)
  );

  // result side back-pressure, switched off during quiet stretches
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // watchdog: any stretch with no item moving on either channel is bounded
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("accessory_power_sequencer verification failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // offer one tick, with random idle cycles ahead of it, and hold it until taken
  // valid is left high on return so back-to-back ticks never drop it
  task automatic send_tick(logic ign, logic lock, logic blink);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid          <= 1'b0;
      in_ignition_level <= 1'($urandom_range(0, 1));
      in_lock_level     <= 1'($urandom_range(0, 1));
      in_blinker_level  <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_ignition_level <= ign;
    in_lock_level     <= lock;
    in_blinker_level  <= blink;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // stop sending and let every outstanding result item come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // all three registers, one per edge, only while nothing is in flight
  task automatic load_settings(logic [15:0] blink_limit, logic [15:0] boot_ticks,
                               logic [15:0] wait_ticks);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RECENT_BLINK_LIMIT;
    cfg_wdata <= blink_limit;
    @(posedge clk);
    cfg_index <= CFG_BOOT_TIMEOUT;
    cfg_wdata <= boot_ticks;
    @(posedge clk);
    cfg_index <= CFG_WAIT_TIMEOUT;
    cfg_wdata <= wait_ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // driving scenarios rather than loose bits, so the sequencer gets past boot
  // and cycles through on, wait, shutdown and back
  task automatic drive_scenarios(int until_count);
    int kind;
    int len;
    while (ticks_sent < until_count) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // ignition held on: short bursts or long ones that can clear boot,
        // with the odd blinker flash for the boot hold
        len = $urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(200, 280);
        if (len > until_count - ticks_sent) len = until_count - ticks_sent;
        repeat (len)
          send_tick(1'b0, $urandom_range(0, 99) < 5, !($urandom_range(0, 99) < 8));
      end else if (kind < 60) begin
        // lock gesture with ignition off: blinker flash with lock high,
        // then lock released while the blinker is still recent
        repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'b1, 1'b0);
        repeat ($urandom_range(0, 2)) send_tick(1'b1, 1'b1, 1'b1);
        repeat ($urandom_range(1, 4))
          send_tick(1'b1, 1'b0, !($urandom_range(0, 99) < 30));
      end else if (kind < 85) begin
        // ignition off and quiet: timeouts and the shutdown key codes run out
        len = $urandom_range(1, 160);
        if (len > until_count - ticks_sent) len = until_count - ticks_sent;
        repeat (len) send_tick(1'b1, $urandom_range(0, 99) < 3, 1'b1);
      end else begin
        // loose pin noise
        repeat ($urandom_range(1, 8))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end
      // now and then hold off until every result item is back
      if ($urandom_range(0, 99) < 4) settle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // opening ticks from the off state at reset settings: every pin combination,
    // early lock out of boot and re-entry from off by ignition or by lock
    for (int i = 23; i >= 0; i--)
      send_tick(OPENING[i*3+2], OPENING[i*3+1], OPENING[i*3]);
    settle();

    // reset settings, first part with no idling on either side
    quiet <= 1'b1;
    drive_scenarios(ticks_sent + 100);
    quiet <= 1'b0;
    drive_scenarios(ticks_sent + PHASE_TICKS - 100);
    settle();

    // everything at zero: blinker never recent, timeouts fire at once
    load_settings(16'd0, 16'd0, 16'd0);
    drive_scenarios(ticks_sent + PHASE_TICKS);
    settle();

    // everything at full scale, opening with an ignition-on stretch
    load_settings(T_MAX, T_MAX, T_MAX);
    repeat (SOAK_TICKS) send_tick(1'b0, 1'b0, 1'b1);
    drive_scenarios(ticks_sent + PHASE_TICKS);
    settle();

    // short random settings so the boot and wait timeouts are reachable
    load_settings(16'($urandom_range(1, 40)), 16'($urandom_range(0, 400)),
                  16'($urandom_range(0, 300)));
    drive_scenarios(ticks_sent + PHASE_TICKS);
    settle();

    if (mismatches == 0 && results_due == 0) begin
      $display("accessory_power_sequencer verification clean");
    end else begin
      $display("accessory_power_sequencer verification failed");
    end
    $finish;
  end

endmodule
